// File: rtl/core/pre_pkg.sv
// shared types and constants of the pinhole range estimator
`default_nettype none
package pre_pkg;

  // field and register widths
  localparam int RULER_W  = 16;
  localparam int FRAC_W   = 24;
  localparam int DIST_W   = 48;
  localparam int FOC_W    = 20;
  localparam int RES_W    = 32;
  localparam int OBJ_W    = 30;
  localparam int CFG_W    = 32;
  localparam int IDX_W    = 2;

  // derived datapath widths
  localparam int IMG_W    = 16 + FRAC_W;
  localparam int HALF_W   = IMG_W / 2;
  localparam int HI_W     = IMG_W - HALF_W;
  localparam int ROOT_W   = IMG_W + 1;
  localparam int SQ_W     = 2 * ROOT_W;
  localparam int SQ_REM_W = ROOT_W + 3;
  localparam int MM_W     = 10;
  localparam int DEN_W    = ROOT_W + MM_W;
  localparam int DREM_W   = DEN_W + 1;
  localparam int NUM_W    = ((OBJ_W + FRAC_W > DEN_W) ? OBJ_W + FRAC_W : DEN_W) + 1;
  localparam int NUM_LO_W = NUM_W / 2;
  localparam int NUM_HI_W = NUM_W - NUM_LO_W;
  localparam int PLO_W    = FOC_W + NUM_LO_W;
  localparam int PHI_W    = FOC_W + NUM_HI_W;
  localparam int PROD_W   = FOC_W + NUM_W;

  // pipeline depths
  localparam int EXT_STAGES = IMG_W;
  localparam int SQ_STAGES  = ROOT_W;
  localparam int DIV_STAGES = DIST_W;

  localparam logic [MM_W-1:0]   MM_TO_UM = MM_W'(1000);
  localparam logic [IMG_W-1:0]  IMG_MAX  = {IMG_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // register indexes
  localparam logic [IDX_W-1:0] REG_FOCAL = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_RES_X = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_RES_Y = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_OBJ   = IDX_W'(3);

  // per-item flags carried down the pipe
  typedef struct packed {
    logic ok;
    logic inf;
    logic ovf;
  } tag_t;

  // extent divider step state
  typedef struct packed {
    logic [RES_W-1:0] rem;
    logic [IMG_W-1:0] quo;
    logic             sat;
  } ext_t;

  // square root step state
  typedef struct packed {
    logic [SQ_W-1:0]     rad;
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
  } sq_t;

  // distance divider step state
  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [DIST_W-1:0] low;
    logic [DIST_W-1:0] quo;
    logic [DEN_W-1:0]  den;
  } dv_t;

endpackage
`default_nettype wire

// File: rtl/core/pre_ext_cell.sv
// one quotient bit of the pixel-to-millimetre extent divider
`default_nettype none
module pre_ext_cell (
  input  logic                      clk,
  input  logic                      en,
  input  logic [pre_pkg::RES_W-1:0] res,
  input  pre_pkg::ext_t             d,
  output pre_pkg::ext_t             q
);
  import pre_pkg::*;

  logic [RES_W:0] sh;
  logic [RES_W:0] diff;
  ext_t           nxt;

  // shift in a zero numerator bit, subtract if it fits
  always_comb begin
    sh   = {d.rem, 1'b0};
    diff = sh - {1'b0, res};
    nxt  = d;
    if (sh >= {1'b0, res}) begin
      nxt.rem = diff[RES_W-1:0];
      nxt.quo = {d.quo[IMG_W-2:0], 1'b1};
    end else begin
      nxt.rem = sh[RES_W-1:0];
      nxt.quo = {d.quo[IMG_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/pre_sqrt_cell.sv
// one root bit of the digit-by-digit integer square root
`default_nettype none
module pre_sqrt_cell (
  input  logic         clk,
  input  logic         en,
  input  pre_pkg::sq_t d,
  output pre_pkg::sq_t q
);
  import pre_pkg::*;

  logic [SQ_REM_W-1:0] rsh;
  logic [SQ_REM_W-1:0] trial;
  sq_t                 nxt;

  // bring down two radicand bits, try root*4+1
  always_comb begin
    rsh     = {d.rem[SQ_REM_W-3:0], d.rad[SQ_W-1:SQ_W-2]};
    trial   = SQ_REM_W'({d.root, 2'b01});
    nxt     = d;
    nxt.rad = {d.rad[SQ_W-3:0], 2'b00};
    if (rsh >= trial) begin
      nxt.rem  = rsh - trial;
      nxt.root = {d.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = rsh;
      nxt.root = {d.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/pre_div_cell.sv
// one quotient bit of the distance divider
`default_nettype none
module pre_div_cell (
  input  logic         clk,
  input  logic         en,
  input  pre_pkg::dv_t d,
  output pre_pkg::dv_t q
);
  import pre_pkg::*;

  logic [DREM_W-1:0] sh;
  logic [DREM_W-1:0] dd;
  dv_t               nxt;

  // shift in the next product bit, subtract the denominator if it fits
  always_comb begin
    sh      = {d.rem[DREM_W-2:0], d.low[DIST_W-1]};
    dd      = {1'b0, d.den};
    nxt     = d;
    nxt.low = {d.low[DIST_W-2:0], 1'b0};
    if (sh >= dd) begin
      nxt.rem = sh - dd;
      nxt.quo = {d.quo[DIST_W-2:0], 1'b1};
    end else begin
      nxt.rem = sh;
      nxt.quo = {d.quo[DIST_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/pinhole_range_estimator.sv
// top level of the pinhole range estimator
//
// Input stream: one ruler measurement per transaction, s_tdata holds the
// signed pixel extents dx and dy. Output stream: one result per input,
// m_tdata holds the distance in micrometres, m_tuser the valid and
// saturated flags. The cfg port writes focal length, the two sensor
// resolutions and the object size; write only while the pipe is empty.
// Throughput is one transaction per cycle while the receiver does not stall.
// The pipe has 138 register stages: 40 extent divider cells, two squaring
// stages, 41 root cells, five stages for denominator, numerator, product
// and divider start, 48 distance divider cells, plus the input and output
// registers. Reset clears the configuration registers to zero (unset) and
// the valid flags, which empties the pipe.
// When the receiver stalls, the whole pipe holds and s_tready drops;
// nothing is lost. An unset register or a zero ruler gives distance 0
// with valid low; an image size that truncates to zero or a distance out
// of range gives the all-ones maximum with saturated high.
`default_nettype none
module pinhole_range_estimator (
  input  logic                      clk,
  input  logic                      rst,
  // ruler_dx [15:0], ruler_dy [31:16]
  input  logic [31:0]               s_tdata,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // distance_um [47:0]
  output logic [47:0]               m_tdata,
  // distance_valid [0], saturated [1]
  output logic [1:0]                m_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic                      cfg_we,
  input  logic [pre_pkg::IDX_W-1:0] cfg_index,
  input  logic [pre_pkg::CFG_W-1:0] cfg_data
);
  import pre_pkg::*;

  logic en;

  // configuration registers
  logic [FOC_W-1:0] focal;
  logic [RES_W-1:0] res_x;
  logic [RES_W-1:0] res_y;
  logic [OBJ_W-1:0] obj;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal <= '0;
      res_x <= '0;
      res_y <= '0;
      obj   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOCAL: focal <= cfg_data[FOC_W-1:0];
        REG_RES_X: res_x <= cfg_data[RES_W-1:0];
        REG_RES_Y: res_y <= cfg_data[RES_W-1:0];
        REG_OBJ:   obj   <= cfg_data[OBJ_W-1:0];
        default:   ;
      endcase
    end
  end

  // global advance: the pipe moves unless a held result blocks it
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input stage: magnitudes and extent divider start
  logic [RULER_W-1:0] dx;
  logic [RULER_W-1:0] dy;
  logic [RULER_W-1:0] mx;
  logic [RULER_W-1:0] my;
  logic [RES_W-1:0]   mx_w;
  logic [RES_W-1:0]   my_w;
  ext_t               ex0_next;
  ext_t               ey0_next;
  tag_t               t0_next;

  always_comb begin
    dx   = s_tdata[RULER_W-1:0];
    dy   = s_tdata[16+RULER_W-1:16];
    mx   = dx[RULER_W-1] ? (~dx + RULER_W'(1)) : dx;
    my   = dy[RULER_W-1] ? (~dy + RULER_W'(1)) : dy;
    mx_w = RES_W'(mx);
    my_w = RES_W'(my);
    ex0_next.rem = mx_w;
    ex0_next.quo = '0;
    ex0_next.sat = mx_w >= res_x;
    ey0_next.rem = my_w;
    ey0_next.quo = '0;
    ey0_next.sat = my_w >= res_y;
    t0_next.ok   = (focal != '0) && (res_x != '0) && (res_y != '0) && (obj != '0) &&
                   ((mx != '0) || (my != '0));
    t0_next.inf  = 1'b0;
    t0_next.ovf  = 1'b0;
  end

  // extent divider chains
  ext_t ex [EXT_STAGES+1];
  ext_t ey [EXT_STAGES+1];
  tag_t te [EXT_STAGES+1];
  logic ve [EXT_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      ex[0] <= ex0_next;
      ey[0] <= ey0_next;
      te[0] <= t0_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ve[0] <= 1'b0;
    end else if (en) begin
      ve[0] <= s_tvalid;
    end
  end

  for (genvar i = 0; i < EXT_STAGES; i++) begin : g_ext
    pre_ext_cell u_cx (.clk(clk), .en(en), .res(res_x), .d(ex[i]), .q(ex[i+1]));
    pre_ext_cell u_cy (.clk(clk), .en(en), .res(res_y), .d(ey[i]), .q(ey[i+1]));

    always_ff @(posedge clk) begin
      if (en) begin
        te[i+1] <= te[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ve[i+1] <= 1'b0;
      end else if (en) begin
        ve[i+1] <= ve[i];
      end
    end
  end

  // squaring stage: partial products of both extents
  logic [IMG_W-1:0]    ext_x;
  logic [IMG_W-1:0]    ext_y;
  logic [2*HI_W-1:0]   x_hh;
  logic [2*HI_W-1:0]   y_hh;
  logic [IMG_W-1:0]    x_hl;
  logic [IMG_W-1:0]    y_hl;
  logic [2*HALF_W-1:0] x_ll;
  logic [2*HALF_W-1:0] y_ll;
  tag_t                tm;
  logic                vm;

  assign ext_x = ex[EXT_STAGES].sat ? IMG_MAX : ex[EXT_STAGES].quo;
  assign ext_y = ey[EXT_STAGES].sat ? IMG_MAX : ey[EXT_STAGES].quo;

  always_ff @(posedge clk) begin
    if (en) begin
      x_hh <= (2*HI_W)'(ext_x[IMG_W-1:HALF_W]) * (2*HI_W)'(ext_x[IMG_W-1:HALF_W]);
      y_hh <= (2*HI_W)'(ext_y[IMG_W-1:HALF_W]) * (2*HI_W)'(ext_y[IMG_W-1:HALF_W]);
      x_hl <= IMG_W'(ext_x[IMG_W-1:HALF_W]) * IMG_W'(ext_x[HALF_W-1:0]);
      y_hl <= IMG_W'(ext_y[IMG_W-1:HALF_W]) * IMG_W'(ext_y[HALF_W-1:0]);
      x_ll <= (2*HALF_W)'(ext_x[HALF_W-1:0]) * (2*HALF_W)'(ext_x[HALF_W-1:0]);
      y_ll <= (2*HALF_W)'(ext_y[HALF_W-1:0]) * (2*HALF_W)'(ext_y[HALF_W-1:0]);
      tm   <= te[EXT_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= ve[EXT_STAGES];
    end
  end

  // sum of squares and root chain start
  logic [SQ_W-1:0] rad_next;
  sq_t             sq [SQ_STAGES+1];
  tag_t            tq [SQ_STAGES+1];
  logic            vq [SQ_STAGES+1];

  always_comb begin
    rad_next = (SQ_W'(x_hh) << (2*HALF_W)) + (SQ_W'(x_hl) << (HALF_W+1)) + SQ_W'(x_ll) +
               (SQ_W'(y_hh) << (2*HALF_W)) + (SQ_W'(y_hl) << (HALF_W+1)) + SQ_W'(y_ll);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].rad  <= rad_next;
      sq[0].rem  <= '0;
      sq[0].root <= '0;
      tq[0]      <= tm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vq[0] <= 1'b0;
    end else if (en) begin
      vq[0] <= vm;
    end
  end

  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sq
    pre_sqrt_cell u_cell (.clk(clk), .en(en), .d(sq[i]), .q(sq[i+1]));

    always_ff @(posedge clk) begin
      if (en) begin
        tq[i+1] <= tq[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[i+1] <= 1'b0;
      end else if (en) begin
        vq[i+1] <= vq[i];
      end
    end
  end

  // denominator: image size in micrometre units
  logic [ROOT_W-1:0] img;
  logic [DEN_W-1:0]  den_d;
  tag_t              td_next;
  tag_t              td;
  logic              vd;

  assign img = sq[SQ_STAGES].root;

  // a zero image size marks an infinite distance
  always_comb begin
    td_next     = tq[SQ_STAGES];
    td_next.inf = img == '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_d <= DEN_W'(img) * DEN_W'(MM_TO_UM);
      td    <= td_next;
    end
  end

  // numerator: object size plus image size
  logic [NUM_W-1:0] num_n;
  logic [DEN_W-1:0] den_n;
  tag_t             tn;
  logic             vn;

  always_ff @(posedge clk) begin
    if (en) begin
      num_n <= NUM_W'({obj, {FRAC_W{1'b0}}}) + NUM_W'(den_d);
      den_n <= den_d;
      tn    <= td;
    end
  end

  // focal length times numerator, in two halves
  logic [PLO_W-1:0] plo;
  logic [PHI_W-1:0] phi;
  logic [DEN_W-1:0] den_p;
  tag_t             tp;
  logic             vp;

  always_ff @(posedge clk) begin
    if (en) begin
      plo   <= PLO_W'(focal) * PLO_W'(num_n[NUM_LO_W-1:0]);
      phi   <= PHI_W'(focal) * PHI_W'(num_n[NUM_W-1:NUM_LO_W]);
      den_p <= den_n;
      tp    <= tn;
    end
  end

  // full product
  logic [PROD_W-1:0] prod;
  logic [DEN_W-1:0]  den_s;
  tag_t              ts;
  logic              vs;

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= (PROD_W'(phi) << NUM_LO_W) + PROD_W'(plo);
      den_s <= den_p;
      ts    <= tp;
    end
  end

  // valid flags of the middle stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
      vn <= 1'b0;
      vp <= 1'b0;
      vs <= 1'b0;
    end else if (en) begin
      vd <= vq[SQ_STAGES];
      vn <= vd;
      vp <= vn;
      vs <= vp;
    end
  end

  // distance divider start and overflow check
  logic [DREM_W-1:0] prod_hi;
  tag_t              tv0_next;
  dv_t               dv [DIV_STAGES+1];
  tag_t              tv [DIV_STAGES+1];
  logic              vv [DIV_STAGES+1];

  assign prod_hi = DREM_W'(prod[PROD_W-1:DIST_W]);

  always_comb begin
    tv0_next     = ts;
    tv0_next.ovf = prod_hi >= DREM_W'(den_s);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].rem <= prod_hi;
      dv[0].low <= prod[DIST_W-1:0];
      dv[0].quo <= '0;
      dv[0].den <= den_s;
      tv[0]     <= tv0_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vv[0] <= 1'b0;
    end else if (en) begin
      vv[0] <= vs;
    end
  end

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    pre_div_cell u_cell (.clk(clk), .en(en), .d(dv[i]), .q(dv[i+1]));

    always_ff @(posedge clk) begin
      if (en) begin
        tv[i+1] <= tv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[i+1] <= 1'b0;
      end else if (en) begin
        vv[i+1] <= vv[i];
      end
    end
  end

  // result selection
  tag_t              tf;
  logic [DIST_W-1:0] dist_next;
  logic              sat_next;

  assign tf = tv[DIV_STAGES];

  always_comb begin
    if (!tf.ok) begin
      dist_next = '0;
      sat_next  = 1'b0;
    end else if (tf.inf || tf.ovf) begin
      dist_next = DIST_MAX;
      sat_next  = 1'b1;
    end else begin
      dist_next = dv[DIV_STAGES].quo;
      sat_next  = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= dist_next;
      m_tuser <= {sat_next, tf.ok};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vv[DIV_STAGES];
    end
  end

  // saturated results are always valid ones
  a_sat_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0])
    else $error("saturated flag without valid flag");

  // an invalid result carries a zero distance
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("invalid result with nonzero distance");

  // a held result blocks the whole pipe, including the input
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(ve[0]))
    else $error("pipe moved while output stalled");

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// self-checking testbench for the pinhole range estimator
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import pre_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0] dist_um;
    logic              valid;
    logic              sat;
  } range_t;

  // one directed row: ruler, camera setting and optional typed result
  typedef struct {
    int          setting;
    logic [15:0] dx;
    logic [15:0] dy;
    bit          typed;
    range_t      want;
  } row_t;

  localparam int SETTINGS_N = 8;
  localparam int IDLE_LIMIT = 5000;

  logic              clk;
  logic              rst;
  logic [31:0]       s_tdata;
  logic              s_tvalid;
  logic              s_tready;
  logic [47:0]       m_tdata;
  logic [1:0]        m_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  // camera registers as last written
  logic [FOC_W-1:0] cam_focal;
  logic [RES_W-1:0] cam_res_x;
  logic [RES_W-1:0] cam_res_y;
  logic [OBJ_W-1:0] cam_obj;

  range_t pending_ranges[$];
  bit     failed;
  bit     calm;
  int     stuck_cycles;
  logic [CFG_W-1:0] setting_regs [SETTINGS_N][4];
  row_t   rows[$];

  pinhole_range_estimator dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // distance from ruler through extents, image size and pinhole relation
  function automatic range_t estimate_range(logic [15:0] dx, logic [15:0] dy);
    logic [16:0]  mx;
    logic [16:0]  my;
    logic [127:0] ex;
    logic [127:0] ey;
    logic [127:0] radicand;
    logic [127:0] img;
    logic [127:0] cand;
    logic [127:0] den;
    logic [127:0] quo;
    range_t       r;
    mx = dx[15] ? (17'd65536 - 17'(dx)) : 17'(dx);
    my = dy[15] ? (17'd65536 - 17'(dy)) : 17'(dy);
    r = '0;
    if (cam_focal == 0 || cam_res_x == 0 || cam_res_y == 0 || cam_obj == 0 ||
        (mx == 0 && my == 0))
      return r;
    ex = (128'(mx) << IMG_W) / 128'(cam_res_x);
    ey = (128'(my) << IMG_W) / 128'(cam_res_y);
    if (ex > 128'(IMG_MAX)) ex = 128'(IMG_MAX);
    if (ey > 128'(IMG_MAX)) ey = 128'(IMG_MAX);
    radicand = ex * ex + ey * ey;
    img = 0;
    for (int b = IMG_W; b >= 0; b--) begin
      cand = img | (128'd1 << b);
      if (cand * cand <= radicand) img = cand;
    end
    r.valid = 1'b1;
    if (img == 0) begin
      r.dist_um = DIST_MAX;
      r.sat = 1'b1;
      return r;
    end
    den = 128'd1000 * img;
    quo = (128'(cam_focal) * ((128'(cam_obj) << FRAC_W) + den)) / den;
    if (quo > 128'(DIST_MAX)) begin
      r.dist_um = DIST_MAX;
      r.sat = 1'b1;
    end else begin
      r.dist_um = quo[DIST_W-1:0];
    end
    return r;
  endfunction

  // wait until every expected result has come back
  task automatic drain();
    while (pending_ranges.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FOCAL: cam_focal = val[FOC_W-1:0];
      REG_RES_X: cam_res_x = val;
      REG_RES_Y: cam_res_y = val;
      REG_OBJ:   cam_obj = val[OBJ_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_camera(logic [CFG_W-1:0] f, logic [CFG_W-1:0] rx,
                             logic [CFG_W-1:0] ry, logic [CFG_W-1:0] o);
    s_tvalid <= 1'b0;
    drain();
    write_reg(REG_FOCAL, f);
    write_reg(REG_RES_X, rx);
    write_reg(REG_RES_Y, ry);
    write_reg(REG_OBJ, o);
  endtask

  // present one ruler, with a random gap before it
  task automatic send_ruler(logic [15:0] dx, logic [15:0] dy);
    if (!calm && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= {dy, dx};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_ranges.push_back(estimate_range(dx, dy));
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    range_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_ranges.size() == 0) begin
        $display("%0t: unexpected result dist_um=%0d flags=%b", $time, m_tdata, m_tuser);
        failed = 1'b1;
      end else begin
        want = pending_ranges.pop_front();
        if (m_tdata !== want.dist_um) begin
          $display("%0t: distance_um expected %0d actual %0d", $time, want.dist_um,
                   m_tdata);
          failed = 1'b1;
        end
        if (m_tuser[0] !== want.valid) begin
          $display("%0t: distance_valid expected %b actual %b", $time, want.valid,
                   m_tuser[0]);
          failed = 1'b1;
        end
        if (m_tuser[1] !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, want.sat, m_tuser[1]);
          failed = 1'b1;
        end
      end
    end
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 7);
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= IDLE_LIMIT) begin
      $display("pinhole_range_estimator: mismatch");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic logic [CFG_W-1:0] pick_res();
    case ($urandom_range(3))
      0: return $urandom_range(1, 32'h0001_0000);
      1: return $urandom_range(32'h0001_0000, 32'h0100_0000);
      2: return 32'hFFFF_FFFF - $urandom_range(15);
      default: return $urandom | 32'h1;
    endcase
  endfunction

  function automatic logic [15:0] pick_ruler();
    case ($urandom_range(7))
      0: return 16'(int'($urandom_range(0, 6)) - 3);
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return 16'(int'($urandom_range(0, 400)) - 200);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    range_t zero_range;
    range_t sat_range;
    int     cur;
    logic [CFG_W-1:0] f;
    logic [CFG_W-1:0] rx;
    logic [CFG_W-1:0] ry;
    logic [CFG_W-1:0] o;

    zero_range = '0;
    sat_range = '{dist_um: DIST_MAX, valid: 1'b1, sat: 1'b1};
    failed = 1'b0;
    calm = 1'b0;
    stuck_cycles = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cam_focal = '0;
    cam_res_x = '0;
    cam_res_y = '0;
    cam_obj = '0;

    // camera settings used by the directed rows: focal, res x, res y, object
    setting_regs[0] = '{0, 0, 0, 0};
    setting_regs[1] = '{1000000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h3FFF_FFFF};
    setting_regs[2] = '{1, 1, 1, 1};
    setting_regs[3] = '{4000, 32'h00C8_0000, 32'h00C8_0000, 1700000};
    setting_regs[4] = '{4000, 32'h00C8_0000, 32'h00C8_0000, 0};
    setting_regs[5] = '{4000, 32'h00C8_0000, 0, 1700000};
    setting_regs[6] = '{4000, 0, 32'h00C8_0000, 1700000};
    setting_regs[7] = '{0, 32'h00C8_0000, 32'h00C8_0000, 1700000};

    // after reset nothing is set
    rows.push_back('{0, 16'h0001, 16'h0001, 1, zero_range});
    rows.push_back('{0, 16'h8000, 16'h7FFF, 1, zero_range});
    // resolutions and object size at their maximum, tiny image sizes overflow the range
    rows.push_back('{1, 16'h0001, 16'h0000, 1, sat_range});
    rows.push_back('{1, 16'h0000, 16'h0000, 1, zero_range});
    rows.push_back('{1, 16'h8000, 16'h8000, 0, zero_range});
    rows.push_back('{1, 16'h7FFF, 16'h0000, 0, zero_range});
    rows.push_back('{1, 16'h0000, 16'hFFFF, 0, zero_range});
    // smallest settings, extents saturate
    rows.push_back('{2, 16'h0001, 16'h0001, 0, zero_range});
    rows.push_back('{2, 16'h8000, 16'h8000, 0, zero_range});
    rows.push_back('{2, 16'h0000, 16'h7FFF, 0, zero_range});
    // ordinary camera
    rows.push_back('{3, 16'h0064, 16'hFF9C, 0, zero_range});
    rows.push_back('{3, 16'hFFFF, 16'h0000, 0, zero_range});
    rows.push_back('{3, 16'h7FFF, 16'h8000, 0, zero_range});
    rows.push_back('{3, 16'h0000, 16'h0000, 1, zero_range});
    // one register left unset
    rows.push_back('{4, 16'h0064, 16'h0064, 1, zero_range});
    rows.push_back('{5, 16'h0064, 16'h0064, 1, zero_range});
    rows.push_back('{6, 16'h0064, 16'h0064, 1, zero_range});
    rows.push_back('{7, 16'h0064, 16'h0064, 1, zero_range});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    cur = 0;
    foreach (rows[i]) begin
      if (rows[i].setting != cur) begin
        cur = rows[i].setting;
        load_camera(setting_regs[cur][0], setting_regs[cur][1],
                    setting_regs[cur][2], setting_regs[cur][3]);
      end
      send_ruler(rows[i].dx, rows[i].dy);
      if (rows[i].typed && pending_ranges[$] != rows[i].want) begin
        $display("%0t: row %0d typed expected %h actual prediction %h", $time, i,
                 rows[i].want, pending_ranges[$]);
        failed = 1'b1;
      end
    end
    s_tvalid <= 1'b0;

    // random phases, each with its own camera
    for (int ph = 0; ph < 10; ph++) begin
      f = (ph == 0) ? 1000000 : $urandom_range(1, 1000000);
      rx = pick_res();
      ry = pick_res();
      o = (ph == 1) ? 32'h3FFF_FFFF : $urandom_range(1, 1000000000);
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0: f = 0;
          1: rx = 0;
          2: ry = 0;
          default: o = 0;
        endcase
      end
      load_camera(f, rx, ry, o);
      calm = (ph == 4);
      for (int n = 0; n < 90; n++) send_ruler(pick_ruler(), pick_ruler());
      s_tvalid <= 1'b0;
      calm = 1'b0;
    end

    drain();
    repeat (150) @(posedge clk);
    if (failed || pending_ranges.size() != 0)
      $display("pinhole_range_estimator: mismatch");
    else
      $display("pinhole_range_estimator: match");
    $finish;
  end
endmodule
`default_nettype wire
